// File: hw/rtl/uls_pkg.sv
// shared constants, codes, types and helper functions of the undoable list store
package uls_pkg;

	// list and history sizes
	localparam int MAX_LEN       = 16;
	localparam int HISTORY_DEPTH = 8;

	// derived widths
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int HIST_W  = $clog2(HISTORY_DEPTH);
	localparam int DEPTH   = HISTORY_DEPTH * MAX_LEN;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// fixed field widths and the comparison width
	localparam int CMD_W      = 3;
	localparam int POS_W      = 8;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int LIST_LEN_W = 5;
	localparam int VER_W      = 3;
	localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNDO   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REDO   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd5;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_IGNORED = 3'd1,
		ST_RANGE   = 3'd2,
		ST_NOREDO  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// snapshot memory access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// (a + b) mod HISTORY_DEPTH for operands below HISTORY_DEPTH
	function automatic logic [HIST_W-1:0] slot_add(input logic [HIST_W-1:0] a,
	                                               input logic [HIST_W-1:0] b);
		logic [HIST_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (HIST_W+1)'(HISTORY_DEPTH))
			sum = sum - (HIST_W+1)'(HISTORY_DEPTH);
		return sum[HIST_W-1:0];
	endfunction

	// flat memory address of element idx in slot
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [HIST_W-1:0] slot,
	                                               input logic [IDX_W-1:0] idx);
		return ADDR_W'(int'(slot) * MAX_LEN + int'(idx));
	endfunction

endpackage

// File: hw/rtl/uls_if.sv
// request and response channel interfaces of the undoable list store
interface uls_req_if import uls_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, command, position, item_value, input ready);
	modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface uls_rsp_if import uls_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] read_value;
	logic [LIST_LEN_W-1:0]    list_length;
	logic [VER_W-1:0]         version_index;

	modport source (output valid, status, read_value, list_length, version_index, input ready);
	modport sink   (input valid, status, read_value, list_length, version_index, output ready);
endinterface

// File: hw/rtl/uls_snap_ram.sv
// snapshot element memory, one write and one registered read port
module uls_snap_ram import uls_pkg::*; (
	input  logic              clk,
	input  ram_req_t          ram_req,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ram_req.we)
			mem[ram_req.waddr] <= ram_req.wdata;
	end

	// registered read port, holds its data while idle
	always_ff @(posedge clk) begin
		if (ram_req.re)
			rdata <= mem[ram_req.raddr];
	end

endmodule

// File: hw/rtl/uls_seq.sv
// command sequencer: version bookkeeping and element copy loop over the memory port
module uls_seq import uls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	uls_req_if.sink           req,
	uls_rsp_if.source         rsp,
	output ram_req_t          ram_req,
	input  logic [DATA_W-1:0] rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_COPY,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;

	// latched command
	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;

	// version bookkeeping
	logic [HIST_W-1:0] cur_ver_q;
	logic [HIST_W-1:0] newest_q;
	logic [HIST_W-1:0] oldest_q;
	logic [LEN_W-1:0]  len_q [HISTORY_DEPTH];

	// copy loop
	logic [HIST_W-1:0] src_slot_q;
	logic [HIST_W-1:0] dst_slot_q;
	logic [LEN_W-1:0]  new_len_q;
	logic [LEN_W-1:0]  ins_p_q;
	logic              erase_q;
	logic [IDX_W-1:0]  j_q;
	logic              wr_vld_s1;
	logic [IDX_W-1:0]  wr_idx_s1;
	logic              use_val_s1;

	// result
	status_t           status_q;
	logic              get_ok_q;

	// current slot and its length
	logic [HIST_W-1:0] cur_slot;
	logic [LEN_W-1:0]  cur_len;
	logic              pos_lt_len;

	assign cur_slot   = slot_add(oldest_q, cur_ver_q);
	assign cur_len    = len_q[cur_slot];
	assign pos_lt_len = CMP_W'(pos_q) < CMP_W'(cur_len);

	// command decode against the current version
	status_t           dec_status;
	logic              dec_change;
	logic              dec_erase;
	logic              dec_get_ok;
	logic [LEN_W-1:0]  dec_len;
	logic [LEN_W-1:0]  dec_p;
	logic              wrap;
	logic [HIST_W-1:0] dst_slot;

	always_comb begin
		dec_status = ST_OK;
		dec_change = 1'b0;
		dec_erase  = 1'b0;
		dec_get_ok = 1'b0;
		dec_len    = cur_len;
		dec_p      = cur_len;
		case (cmd_q)
			CMD_INSERT, CMD_APPEND: begin
				if (cur_len >= LEN_W'(MAX_LEN)) begin
					dec_status = ST_FULL;
				end else begin
					dec_change = 1'b1;
					dec_len    = cur_len + 1'b1;
					if (cmd_q == CMD_INSERT && pos_lt_len)
						dec_p = LEN_W'(pos_q);
				end
			end
			CMD_ERASE: begin
				if (!pos_lt_len) begin
					dec_status = ST_IGNORED;
				end else begin
					dec_change = 1'b1;
					dec_erase  = 1'b1;
					dec_len    = cur_len - 1'b1;
					dec_p      = LEN_W'(pos_q);
				end
			end
			CMD_UNDO: begin
				if (cur_ver_q == '0)
					dec_status = ST_IGNORED;
			end
			CMD_REDO: begin
				if (cur_ver_q == newest_q)
					dec_status = ST_NOREDO;
			end
			CMD_GET: begin
				if (!pos_lt_len)
					dec_status = ST_RANGE;
				else
					dec_get_ok = 1'b1;
			end
			default: begin
				dec_status = ST_IGNORED;
			end
		endcase
		// a full history reuses the oldest slot for the new version
		wrap     = cur_ver_q == HIST_W'(HISTORY_DEPTH - 1);
		dst_slot = wrap ? oldest_q : slot_add(oldest_q, cur_ver_q + 1'b1);
	end

	// source element for destination index j
	logic [LEN_W-1:0] j_ext;
	logic             use_val;
	logic [IDX_W-1:0] src_idx;

	always_comb begin
		j_ext   = LEN_W'(j_q);
		use_val = 1'b0;
		src_idx = j_q;
		if (erase_q) begin
			if (j_ext >= ins_p_q)
				src_idx = j_q + 1'b1;
		end else if (j_ext == ins_p_q) begin
			use_val = 1'b1;
		end else if (j_ext > ins_p_q) begin
			src_idx = j_q - 1'b1;
		end
	end

	// memory port: copy reads and get read share the read port
	always_comb begin
		ram_req.we    = wr_vld_s1;
		ram_req.waddr = mem_addr(dst_slot_q, wr_idx_s1);
		ram_req.wdata = use_val_s1 ? val_q : rdata;
		ram_req.re    = 1'b0;
		ram_req.raddr = mem_addr(src_slot_q, src_idx);
		if (state_q == S_COPY) begin
			ram_req.re = !use_val;
		end else if (state_q == S_DECIDE) begin
			ram_req.re    = dec_get_ok;
			ram_req.raddr = mem_addr(cur_slot, IDX_W'(pos_q));
		end
	end

	assign req.ready = state_q == S_IDLE;

	// sequencer state, bookkeeping and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			cmd_q             <= '0;
			pos_q             <= '0;
			val_q             <= '0;
			cur_ver_q         <= '0;
			newest_q          <= '0;
			oldest_q          <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++)
				len_q[i] <= '0;
			src_slot_q        <= '0;
			dst_slot_q        <= '0;
			new_len_q         <= '0;
			ins_p_q           <= '0;
			erase_q           <= 1'b0;
			j_q               <= '0;
			wr_vld_s1         <= 1'b0;
			wr_idx_s1         <= '0;
			use_val_s1        <= 1'b0;
			status_q          <= ST_OK;
			get_ok_q          <= 1'b0;
			rsp.valid         <= 1'b0;
			rsp.status        <= '0;
			rsp.read_value    <= '0;
			rsp.list_length   <= '0;
			rsp.version_index <= '0;
		end else begin
			wr_vld_s1 <= state_q == S_COPY;
			// the done state reloads the result register itself
			if (rsp.valid && rsp.ready && state_q != S_DONE)
				rsp.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.command;
						pos_q   <= req.position;
						val_q   <= req.item_value;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q <= dec_status;
					get_ok_q <= dec_get_ok;
					state_q  <= S_DONE;
					if (dec_change) begin
						src_slot_q       <= cur_slot;
						dst_slot_q       <= dst_slot;
						new_len_q        <= dec_len;
						ins_p_q          <= dec_p;
						erase_q          <= dec_erase;
						j_q              <= '0;
						len_q[dst_slot]  <= dec_len;
						if (wrap) begin
							oldest_q <= slot_add(oldest_q, HIST_W'(1));
							newest_q <= cur_ver_q;
						end else begin
							cur_ver_q <= cur_ver_q + 1'b1;
							newest_q  <= cur_ver_q + 1'b1;
						end
						if (dec_len != '0)
							state_q <= S_COPY;
					end else if (cmd_q == CMD_UNDO && dec_status == ST_OK) begin
						cur_ver_q <= cur_ver_q - 1'b1;
					end else if (cmd_q == CMD_REDO && dec_status == ST_OK) begin
						cur_ver_q <= cur_ver_q + 1'b1;
					end
				end
				S_COPY: begin
					// read source now, write destination in the next cycle
					wr_idx_s1  <= j_q;
					use_val_s1 <= use_val;
					if (j_ext == new_len_q - 1'b1)
						state_q <= S_DRAIN;
					else
						j_q <= j_q + 1'b1;
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid         <= 1'b1;
						rsp.status        <= status_q;
						rsp.read_value    <= get_ok_q ? rdata : '0;
						rsp.list_length   <= LIST_LEN_W'(cur_len);
						rsp.version_index <= VER_W'(cur_ver_q);
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/undoable_list_store.sv
// top level of the undoable list store
//
//   channel | dir | fields                                           | accepted when
//   req     | in  | command, position, item_value                    | valid && ready
//   rsp     | out | status, read_value, list_length, version_index   | valid && ready
//
// One command at a time. Undo, redo, get and rejected commands go from the decide
// state straight to the done state, which loads the result register. A change
// first runs the element copy loop through the single snapshot memory port, one
// element per cycle, then drains the last write; an erase that empties the list
// copies nothing. Reset leaves an empty list as version zero and needs no
// clearing pass. A stalled result holds in the output register; the next
// command is taken once it is loaded.
module undoable_list_store import uls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	uls_req_if.sink   req,
	uls_rsp_if.source rsp
);

	ram_req_t          ram_req;
	logic [DATA_W-1:0] rdata;

	// sequencer
	uls_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.ram_req (ram_req),
		.rdata   (rdata)
	);

	// snapshot elements
	uls_snap_ram u_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (rdata)
	);

endmodule

// File: hw/rtl/uls_checker.sv
// port-level checks of the undoable list store and their binding
module uls_checker import uls_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [STATUS_W-1:0]   status,
	input logic [DATA_W-1:0]     read_value,
	input logic [LIST_LEN_W-1:0] list_length
);

	// one command in flight: no transfer right after a request transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a command is in flight");

	// only a successful get returns data
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> read_value == '0)
		else $error("nonzero read value on a non-ok result");

	// list full is reported only at the maximum length
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> list_length == LIST_LEN_W'(MAX_LEN))
		else $error("list full reported below maximum length");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value))
		else $error("stalled result changed");

endmodule

bind undoable_list_store uls_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.read_value  (rsp.read_value),
	.list_length (rsp.list_length)
);

// File: bench/tb_undoable_list_store.sv
// testbench for the undoable list store: directed and random commands against a local history model
module tb_undoable_list_store;
	import uls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// command codes the block treats as unknown
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	// random mix flavors
	localparam int MIX_SHRINK = 0;
	localparam int MIX_EVEN   = 1;
	localparam int MIX_GROW   = 2;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES      = 40;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [LIST_LEN_W-1:0]    list_length;
		logic [VER_W-1:0]         version_index;
	} list_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	uls_req_if req ();
	uls_rsp_if rsp ();

	undoable_list_store u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// history model state
	logic signed [DATA_W-1:0] hist_data [HISTORY_DEPTH][MAX_LEN];
	logic [LIST_LEN_W-1:0]    hist_len  [HISTORY_DEPTH];
	logic [HIST_W-1:0]        cur_ver;
	logic [HIST_W-1:0]        newest_ver;
	logic [HIST_W-1:0]        oldest_slot;

	list_outcome_t outcome_q [$];
	int            err_count = 0;
	logic          idle_on = 1'b1;
	logic          long_hold = 1'b0;
	int            rsp_idle_left = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// physical slot that holds a version
	function automatic logic [HIST_W-1:0] slot_of_version(input logic [HIST_W-1:0] v);
		return HIST_W'((int'(oldest_slot) + int'(v)) % HISTORY_DEPTH);
	endfunction

	// length of the current version
	function automatic int current_length();
		return int'(hist_len[slot_of_version(cur_ver)]);
	endfunction

	// apply one command to the history and return the result it causes
	function automatic list_outcome_t advance_history(input logic [CMD_W-1:0] cmd,
	                                                  input logic [POS_W-1:0] pos,
	                                                  input logic signed [DATA_W-1:0] val);
		list_outcome_t            o;
		logic signed [DATA_W-1:0] work [MAX_LEN];
		logic [HIST_W-1:0]        src, dst;
		int                       len, p, i;
		bit                       changed;
		src = slot_of_version(cur_ver);
		len = int'(hist_len[src]);
		for (i = 0; i < MAX_LEN; i++)
			work[i] = hist_data[src][i];
		o.status = ST_OK;
		o.read_value = '0;
		changed = 1'b0;
		case (cmd)
			CMD_INSERT: begin
				if (len >= MAX_LEN) begin
					o.status = ST_FULL;
				end else begin
					// insert past the end lands at the end
					p = (int'(pos) < len) ? int'(pos) : len;
					for (i = len; i > p; i--)
						work[i] = work[i-1];
					work[p] = val;
					len = len + 1;
					changed = 1'b1;
				end
			end
			CMD_ERASE: begin
				if (int'(pos) >= len) begin
					o.status = ST_IGNORED;
				end else begin
					for (i = int'(pos); i + 1 < len; i++)
						work[i] = work[i+1];
					work[len-1] = '0;
					len = len - 1;
					changed = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (len >= MAX_LEN) begin
					o.status = ST_FULL;
				end else begin
					work[len] = val;
					len = len + 1;
					changed = 1'b1;
				end
			end
			CMD_UNDO: begin
				if (cur_ver != '0)
					cur_ver = cur_ver - 1'b1;
				else
					o.status = ST_IGNORED;
			end
			CMD_REDO: begin
				if (cur_ver < newest_ver)
					cur_ver = cur_ver + 1'b1;
				else
					o.status = ST_NOREDO;
			end
			CMD_GET: begin
				if (int'(pos) >= len)
					o.status = ST_RANGE;
				else
					o.read_value = work[pos];
			end
			default: begin
				o.status = ST_IGNORED;
			end
		endcase
		// a change becomes the newest version, dropping the oldest when history is full
		if (changed) begin
			if (int'(cur_ver) + 1 >= HISTORY_DEPTH) begin
				oldest_slot = HIST_W'((int'(oldest_slot) + 1) % HISTORY_DEPTH);
				cur_ver = HIST_W'(HISTORY_DEPTH - 1);
			end else begin
				cur_ver = cur_ver + 1'b1;
			end
			newest_ver = cur_ver;
			dst = slot_of_version(cur_ver);
			for (i = 0; i < MAX_LEN; i++)
				hist_data[dst][i] = work[i];
			hist_len[dst] = LIST_LEN_W'(len);
		end
		o.list_length = hist_len[slot_of_version(cur_ver)];
		o.version_index = VER_W'(cur_ver);
		return o;
	endfunction

	// count a failure and print it
	task automatic flag_error(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// offer one command and wait for its transfer
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
	                        input logic signed [DATA_W-1:0] val);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.position <= pos;
		req.item_value <= val;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		outcome_q.insert(outcome_q.size(), advance_history(cmd, pos, val));
	endtask

	// pick a command by flavor and send it with random content
	task automatic send_random(input int flavor);
		int               r, len;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		len = current_length();
		case (flavor)
			MIX_GROW: begin
				if (r < 30)      cmd = CMD_INSERT;
				else if (r < 60) cmd = CMD_APPEND;
				else if (r < 65) cmd = CMD_ERASE;
				else if (r < 73) cmd = CMD_UNDO;
				else if (r < 80) cmd = CMD_REDO;
				else if (r < 97) cmd = CMD_GET;
				else             cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			end
			MIX_SHRINK: begin
				if (r < 8)       cmd = CMD_INSERT;
				else if (r < 15) cmd = CMD_APPEND;
				else if (r < 50) cmd = CMD_ERASE;
				else if (r < 65) cmd = CMD_UNDO;
				else if (r < 75) cmd = CMD_REDO;
				else if (r < 97) cmd = CMD_GET;
				else             cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			end
			default: begin
				if (r < 18)      cmd = CMD_INSERT;
				else if (r < 36) cmd = CMD_ERASE;
				else if (r < 50) cmd = CMD_APPEND;
				else if (r < 65) cmd = CMD_UNDO;
				else if (r < 77) cmd = CMD_REDO;
				else if (r < 97) cmd = CMD_GET;
				else             cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			end
		endcase
		// mostly positions near the live range, sometimes anywhere
		if ($urandom_range(0, 3) == 0)
			pos = POS_W'($urandom_range(0, 255));
		else
			pos = POS_W'($urandom_range(0, len + 1));
		send_cmd(cmd, pos, $urandom());
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_results_drained();
		req.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold) begin
			rsp.ready <= 1'b0;
		end else if (rsp_idle_left > 0) begin
			rsp.ready <= 1'b0;
			rsp_idle_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			rsp.ready <= 1'b0;
			rsp_idle_left = $urandom_range(1, 13) - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin
		list_outcome_t exp_o;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (outcome_q.size() == 0) begin
				flag_error("result with nothing outstanding");
			end else begin
				exp_o = outcome_q.pop_front();
				if (rsp.status !== exp_o.status || rsp.read_value !== exp_o.read_value ||
				    rsp.list_length !== exp_o.list_length ||
				    rsp.version_index !== exp_o.version_index)
					flag_error($sformatf("got %0d %0d %0d %0d, want %0d %0d %0d %0d",
						rsp.status, rsp.read_value, rsp.list_length, rsp.version_index,
						exp_o.status, exp_o.read_value, exp_o.list_length,
						exp_o.version_index));
			end
		end
	end

	// empty list: every command that cannot act
	task automatic test_empty_list();
		send_cmd(CMD_UNDO, 8'd0, 32'sd0);
		send_cmd(CMD_REDO, 8'd0, 32'sd0);
		send_cmd(CMD_GET, 8'd0, 32'sd0);
		send_cmd(CMD_GET, 8'd255, 32'sd0);
		send_cmd(CMD_ERASE, 8'd0, 32'sd0);
		send_cmd(CMD_ERASE, 8'd255, 32'sd0);
		send_cmd(CMD_UNUSED_LO, 8'd170, $urandom());
		send_cmd(CMD_UNUSED_HI, 8'd85, $urandom());
	endtask

	// basic edits, reads, undo and redo
	task automatic test_edit_basics();
		send_cmd(CMD_INSERT, 8'd255, 32'sh7fff_ffff);
		send_cmd(CMD_APPEND, 8'd0, 32'sh8000_0000);
		send_cmd(CMD_INSERT, 8'd0, -32'sd1);
		send_cmd(CMD_INSERT, 8'd1, 32'sd0);
		send_cmd(CMD_GET, 8'd0, 32'sd0);
		send_cmd(CMD_GET, 8'd1, 32'sd0);
		send_cmd(CMD_GET, 8'd2, 32'sd0);
		send_cmd(CMD_GET, 8'd3, 32'sd0);
		send_cmd(CMD_GET, 8'd4, 32'sd0);
		send_cmd(CMD_ERASE, 8'd1, 32'sd0);
		send_cmd(CMD_ERASE, 8'd200, 32'sd0);
		send_cmd(CMD_UNDO, 8'd0, 32'sd0);
		send_cmd(CMD_UNDO, 8'd0, 32'sd0);
		send_cmd(CMD_REDO, 8'd0, 32'sd0);
		send_cmd(CMD_REDO, 8'd0, 32'sd0);
		send_cmd(CMD_REDO, 8'd0, 32'sd0);
	endtask

	// fill the list, overflow the history, walk to the oldest version and partly back
	task automatic test_full_list();
		repeat (MAX_LEN + 2) send_cmd(CMD_APPEND, POS_W'($urandom_range(0, 255)), $urandom());
		send_cmd(CMD_INSERT, POS_W'($urandom_range(0, 255)), $urandom());
		send_cmd(CMD_GET, POS_W'(MAX_LEN - 1), 32'sd0);
		send_cmd(CMD_GET, POS_W'(MAX_LEN), 32'sd0);
		repeat (HISTORY_DEPTH) send_cmd(CMD_UNDO, 8'd0, 32'sd0);
		repeat (3) send_cmd(CMD_REDO, 8'd0, 32'sd0);
		// a change cuts off the redo versions
		send_cmd(CMD_ERASE, 8'd0, 32'sd0);
		send_cmd(CMD_REDO, 8'd0, 32'sd0);
	endtask

	// receiver holds off while commands keep coming, then the sender waits out the backlog
	task automatic test_backpressure();
		fork
			begin
				long_hold <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold <= 1'b0;
			end
		join_none
		repeat (12) send_random(MIX_EVEN);
		wait_results_drained();
	endtask

	// random commands in segments that grow, shrink or hover
	task automatic test_random_mix(input int n_items);
		int k, flavor;
		flavor = MIX_GROW;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				flavor = $urandom_range(MIX_SHRINK, MIX_GROW);
			send_random(flavor);
		end
	endtask

	// back to back traffic with no idling
	task automatic test_no_idle(input int n_items);
		idle_on <= 1'b0;
		test_random_mix(n_items);
		wait_results_drained();
	endtask

	// run limit
	initial begin
		#(5_000_000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		req.valid = 1'b0;
		req.command = CMD_GET;
		req.position = '0;
		req.item_value = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		// empty list as version zero
		for (int s = 0; s < HISTORY_DEPTH; s++) begin
			hist_len[s] = '0;
			for (int e = 0; e < MAX_LEN; e++)
				hist_data[s][e] = '0;
		end
		cur_ver = '0;
		newest_ver = '0;
		oldest_slot = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_basics();
		test_full_list();
		test_backpressure();
		test_random_mix(720);
		test_no_idle(150);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
